/* hw/rtl/spbe_pkg.sv */
`timescale 1ns / 1ps
package spbe_pkg;

    // action codes
    localparam logic [2:0] ACT_CLEAR     = 3'd0;
    localparam logic [2:0] ACT_BEGIN_ROW = 3'd1;
    localparam logic [2:0] ACT_ROW_BYTE  = 3'd2;
    localparam logic [2:0] ACT_READ_ROW  = 3'd3;
    localparam logic [2:0] ACT_SEAL      = 3'd4;
    localparam logic [2:0] ACT_READ_PAGE = 3'd5;
    localparam logic [2:0] ACT_WRITE_PAGE = 3'd6;
    localparam logic [2:0] ACT_VERIFY    = 3'd7;

    // header layout
    localparam int HDR_BYTES     = 16;
    localparam int HDR_TYPE      = 4;
    localparam int HDR_SLOTS     = 8;
    localparam int HDR_FREE      = 10;
    localparam int HDR_CHECKSUM  = 12;
    localparam int SLOT_BASE     = 16;
    localparam int SLOT_SIZE     = 8;
    localparam int ENTRY_BYTES   = 6;

    // internal page address width, covers the largest page
    localparam int ADDR_W = 17;

    // register byte addresses
    localparam logic [2:0] REG_PAGE_NUMBER = 3'd0;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  data_byte;
        logic [15:0] row_length;
        logic [8:0]  slot_index;
        logic [15:0] byte_index;
        logic [12:0] address;
        logic        addr_ok;
    } spbe_cmd_t;

    typedef struct packed {
        logic        ok;
        logic [7:0]  read_byte;
        logic [15:0] row_length_out;
        logic [15:0] slot_count;
        logic [31:0] checksum;
    } spbe_result_t;

endpackage

/* hw/rtl/spbe_front.sv */
`timescale 1ns / 1ps
module spbe_front
    import spbe_pkg::*;
#(
    parameter int PAGE_BYTES = 8192
) (
    input  logic [2:0]  action,
    input  logic [7:0]  data_byte,
    input  logic [15:0] row_length,
    input  logic [8:0]  slot_index,
    input  logic [15:0] byte_index,
    input  logic [12:0] address,
    output spbe_cmd_t   cmd
);

    // pack the item and flag raw addresses beyond the page
    always_comb
    begin
        cmd.action     = action;
        cmd.data_byte  = data_byte;
        cmd.row_length = row_length;
        cmd.slot_index = slot_index;
        cmd.byte_index = byte_index;
        cmd.address    = address;
        cmd.addr_ok    = ({4'b0, address} < 17'(PAGE_BYTES));
    end

endmodule

/* hw/rtl/spbe_cmdq.sv */
`timescale 1ns / 1ps
module spbe_cmdq
    import spbe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  spbe_cmd_t push_cmd,
    output logic      not_full,
    input  logic      pop,
    output logic      not_empty,
    output spbe_cmd_t head_cmd
);

    spbe_cmd_t   entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

/* hw/rtl/spbe_back.sv */
`timescale 1ns / 1ps
module spbe_back
    import spbe_pkg::*;
#(
    parameter int PAGE_BYTES  = 8192,
    parameter int HEADER_AREA = 256,
    parameter int SLOT_LIMIT  = 512
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [31:0]  page_number,
    input  logic         q_valid,
    input  spbe_cmd_t    q_cmd,
    output logic         pop,
    output logic         init_done,
    output logic         out_valid,
    input  logic         out_ready,
    output spbe_result_t result
);

    localparam int AW = $clog2(PAGE_BYTES);
    localparam int CW = AW + 1;
    localparam int ROW_AREA_BASE = HEADER_AREA + SLOT_LIMIT * SLOT_SIZE;
    localparam logic [15:0] FREE_INIT = 16'(ROW_AREA_BASE);

    localparam logic [3:0] ST_INIT  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_CLEAR = 4'd2;
    localparam logic [3:0] ST_BEGIN = 4'd3;
    localparam logic [3:0] ST_SLOT  = 4'd4;
    localparam logic [3:0] ST_FETCH = 4'd5;
    localparam logic [3:0] ST_SUM   = 4'd6;

    logic [7:0]         mem [PAGE_BYTES];
    logic [7:0]         rdata_reg;

    logic [3:0]         state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [7:0]         hdr_reg [HDR_BYTES];
    logic [7:0]         hdr_next [HDR_BYTES];
    spbe_cmd_t          cmd_reg, cmd_next;
    logic [ADDR_W-1:0]  e_reg, e_next;
    logic [47:0]        entry_reg, entry_next;
    logic [31:0]        sum_reg, sum_next;
    logic [ADDR_W-1:0]  ptr_reg, ptr_next;
    logic [15:0]        left_reg, left_next;
    logic               out_valid_reg, out_valid_next;
    spbe_result_t       res_reg, res_next;
    logic               rd_pend_reg;
    logic [ADDR_W-1:0]  rd_addr_reg;

    logic               rd_req;
    logic [ADDR_W-1:0]  rd_addr;
    logic [7:0]         rd_byte;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [7:0]         wr_data;
    logic               clr_en;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [7:0]         mem_wdata;
    logic               res_load;
    logic               res_ok;
    logic [7:0]         res_rb;
    logic [15:0]        res_rlo;
    logic [31:0]        res_sum;

    logic [15:0]        nslots;
    logic [15:0]        freeo;
    logic [ADDR_W-1:0]  e_calc;
    logic [31:0]        off;
    logic [15:0]        len;
    logic [2:0]         cap_idx;

    assign init_done = (state_reg != ST_INIT);
    assign out_valid = out_valid_reg;
    assign result    = res_reg;
    assign nslots    = {hdr_reg[HDR_SLOTS + 1], hdr_reg[HDR_SLOTS]};
    assign freeo     = {hdr_reg[HDR_FREE + 1], hdr_reg[HDR_FREE]};
    assign off       = entry_reg[31:0];
    assign len       = entry_reg[47:32];
    assign cap_idx   = cnt_reg[2:0] - 3'd1;

    // page byte for the read issued in the cycle before
    always_comb
    begin
        if (rd_addr_reg < ADDR_W'(HDR_BYTES))
        begin
            rd_byte = hdr_reg[rd_addr_reg[3:0]];
        end
        else if (rd_addr_reg < ADDR_W'(PAGE_BYTES))
        begin
            rd_byte = rdata_reg;
        end
        else
        begin
            rd_byte = 8'd0;
        end
    end

    // page memory, header bytes live in flops
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr[AW-1:0]];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hdr_next   = hdr_reg;
        cmd_next   = cmd_reg;
        e_next     = e_reg;
        entry_next = entry_reg;
        sum_next   = sum_reg;
        ptr_next   = ptr_reg;
        left_next  = left_reg;
        pop        = 1'b0;
        rd_req     = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = 8'd0;
        clr_en     = 1'b0;
        res_load   = 1'b0;
        res_ok     = 1'b0;
        res_rb     = 8'd0;
        res_rlo    = 16'd0;
        res_sum    = 32'd0;
        e_calc     = '0;

        unique case (state_reg) inside
            ST_INIT, ST_CLEAR:
            begin
                clr_en   = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(PAGE_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                    if (state_reg == ST_CLEAR)
                    begin
                        res_load = 1'b1;
                        res_ok   = 1'b1;
                    end
                end
            end
            ST_IDLE:
            begin
                if (q_valid && (!out_valid_reg || out_ready))
                begin
                    pop      = 1'b1;
                    cmd_next = q_cmd;
                    unique case (q_cmd.action) inside
                        ACT_CLEAR:
                        begin
                            for (int i = 0; i < HDR_BYTES; i++)
                            begin
                                hdr_next[i] = 8'd0;
                            end
                            for (int i = 0; i < 4; i++)
                            begin
                                hdr_next[i] = page_number[8*i +: 8];
                            end
                            hdr_next[HDR_TYPE]     = 8'd1;
                            hdr_next[HDR_FREE]     = FREE_INIT[7:0];
                            hdr_next[HDR_FREE + 1] = FREE_INIT[15:8];
                            left_next  = 16'd0;
                            ptr_next   = '0;
                            cnt_next   = CW'(HDR_BYTES);
                            state_next = ST_CLEAR;
                        end
                        ACT_BEGIN_ROW:
                        begin
                            if (nslots < 16'(SLOT_LIMIT) &&
                                ({2'b0, freeo} + {2'b0, q_cmd.row_length}) <= 18'(PAGE_BYTES))
                            begin
                                e_next = ADDR_W'(SLOT_BASE) + ADDR_W'({nslots, 3'b000});
                                entry_next = {q_cmd.row_length, 16'd0, freeo};
                                {hdr_next[HDR_FREE + 1], hdr_next[HDR_FREE]} =
                                    freeo + q_cmd.row_length;
                                {hdr_next[HDR_SLOTS + 1], hdr_next[HDR_SLOTS]} =
                                    nslots + 16'd1;
                                ptr_next   = ADDR_W'(freeo);
                                left_next  = q_cmd.row_length;
                                cnt_next   = '0;
                                state_next = ST_BEGIN;
                            end
                            else
                            begin
                                res_load = 1'b1;
                            end
                        end
                        ACT_ROW_BYTE:
                        begin
                            res_load = 1'b1;
                            if (left_reg != 16'd0)
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = ptr_reg;
                                wr_data   = q_cmd.data_byte;
                                ptr_next  = ptr_reg + ADDR_W'(1);
                                left_next = left_reg - 16'd1;
                                res_ok    = 1'b1;
                            end
                        end
                        ACT_READ_ROW:
                        begin
                            e_calc = ADDR_W'(SLOT_BASE) + ADDR_W'({q_cmd.slot_index, 3'b000});
                            if ({7'b0, q_cmd.slot_index} < nslots &&
                                (e_calc + ADDR_W'(SLOT_SIZE)) <= ADDR_W'(PAGE_BYTES))
                            begin
                                e_next     = e_calc;
                                cnt_next   = '0;
                                state_next = ST_SLOT;
                            end
                            else
                            begin
                                res_load = 1'b1;
                            end
                        end
                        ACT_SEAL, ACT_VERIFY:
                        begin
                            cnt_next   = '0;
                            sum_next   = 32'd0;
                            state_next = ST_SUM;
                        end
                        ACT_READ_PAGE:
                        begin
                            if (q_cmd.addr_ok)
                            begin
                                rd_req     = 1'b1;
                                rd_addr    = ADDR_W'(q_cmd.address);
                                state_next = ST_FETCH;
                            end
                            else
                            begin
                                res_load = 1'b1;
                            end
                        end
                        ACT_WRITE_PAGE:
                        begin
                            res_load = 1'b1;
                            if (q_cmd.addr_ok)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = ADDR_W'(q_cmd.address);
                                wr_data = q_cmd.data_byte;
                                res_ok  = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_BEGIN:
            begin
                // slot entry: offset then length, little-endian
                wr_en    = 1'b1;
                wr_addr  = e_reg + ADDR_W'(cnt_reg);
                wr_data  = entry_reg[{cnt_reg[2:0], 3'b000} +: 8];
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(ENTRY_BYTES - 1))
                begin
                    res_load   = 1'b1;
                    res_ok     = 1'b1;
                    res_rlo    = cmd_reg.row_length;
                    state_next = ST_IDLE;
                end
            end
            ST_SLOT:
            begin
                if (cnt_reg < CW'(ENTRY_BYTES))
                begin
                    rd_req  = 1'b1;
                    rd_addr = e_reg + ADDR_W'(cnt_reg);
                end
                if (rd_pend_reg && cnt_reg != '0 && cnt_reg <= CW'(ENTRY_BYTES))
                begin
                    entry_next[{cap_idx, 3'b000} +: 8] = rd_byte;
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(ENTRY_BYTES + 1))
                begin
                    if ({16'd0, cmd_reg.byte_index} < {16'd0, len} &&
                        off < 32'(PAGE_BYTES) &&
                        {16'd0, cmd_reg.byte_index} < (32'(PAGE_BYTES) - off))
                    begin
                        rd_req     = 1'b1;
                        rd_addr    = off[ADDR_W-1:0] + ADDR_W'(cmd_reg.byte_index);
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        res_load   = 1'b1;
                        res_rlo    = len;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FETCH:
            begin
                res_load   = 1'b1;
                res_ok     = 1'b1;
                res_rb     = rd_byte;
                res_rlo    = (cmd_reg.action == ACT_READ_ROW) ? len : 16'd0;
                state_next = ST_IDLE;
            end
            ST_SUM:
            begin
                // one byte a cycle, checksum field left out
                if (cnt_reg < CW'(PAGE_BYTES))
                begin
                    rd_req  = 1'b1;
                    rd_addr = ADDR_W'(cnt_reg);
                end
                if (rd_pend_reg && (rd_addr_reg < ADDR_W'(HDR_CHECKSUM) ||
                                    rd_addr_reg > ADDR_W'(HDR_CHECKSUM + 3)))
                begin
                    sum_next = sum_reg + {24'd0, rd_byte};
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(PAGE_BYTES + 1))
                begin
                    res_load = 1'b1;
                    res_sum  = sum_reg;
                    if (cmd_reg.action == ACT_SEAL)
                    begin
                        res_ok = 1'b1;
                        for (int i = 0; i < 4; i++)
                        begin
                            hdr_next[HDR_CHECKSUM + i] = sum_reg[8*i +: 8];
                        end
                    end
                    else
                    begin
                        res_ok = ({hdr_reg[HDR_CHECKSUM + 3], hdr_reg[HDR_CHECKSUM + 2],
                                   hdr_reg[HDR_CHECKSUM + 1], hdr_reg[HDR_CHECKSUM]}
                                  == sum_reg);
                        for (int i = 0; i < 4; i++)
                        begin
                            hdr_next[HDR_CHECKSUM + i] = 8'd0;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // byte writes land in header flops or memory
        if (wr_en && wr_addr < ADDR_W'(HDR_BYTES))
        begin
            hdr_next[wr_addr[3:0]] = wr_data;
        end
    end

    // memory write port
    always_comb
    begin
        mem_we    = clr_en || (wr_en && wr_addr >= ADDR_W'(HDR_BYTES) &&
                               wr_addr < ADDR_W'(PAGE_BYTES));
        mem_waddr = clr_en ? cnt_reg[AW-1:0] : wr_addr[AW-1:0];
        mem_wdata = clr_en ? 8'd0 : wr_data;
    end

    // result register
    always_comb
    begin
        res_next = res_reg;
        if (res_load)
        begin
            res_next.ok             = res_ok;
            res_next.read_byte      = res_rb;
            res_next.row_length_out = res_rlo;
            res_next.slot_count     = {hdr_next[HDR_SLOTS + 1], hdr_next[HDR_SLOTS]};
            res_next.checksum       = res_sum;
        end
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        e_reg       <= e_next;
        entry_reg   <= entry_next;
        sum_reg     <= sum_next;
        res_reg     <= res_next;
        rd_addr_reg <= rd_addr;
    end

    // control state and header
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= CW'(HDR_BYTES);
            ptr_reg       <= '0;
            left_reg      <= 16'd0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            for (int i = 0; i < HDR_BYTES; i++)
            begin
                hdr_reg[i] <= 8'd0;
            end
            hdr_reg[HDR_TYPE]     <= 8'd1;
            hdr_reg[HDR_FREE]     <= FREE_INIT[7:0];
            hdr_reg[HDR_FREE + 1] <= FREE_INIT[15:8];
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= rd_req;
            hdr_reg       <= hdr_next;
        end
    end

endmodule

/* hw/rtl/slotted_page_buffer_engine_core.sv */
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// in        input      in_valid/in_ready  action data_byte row_length slot_index
//                                         byte_index address
// out       output     out_valid/out_ready ok read_byte row_length_out slot_count checksum
// cfg       input      apb psel/penable   page_number at byte address 0
//
// row byte, write page and commands rejected in idle answer straight from idle;
// read page passes through the fetch state; begin row writes the six slot entry
// bytes, one per cycle on the memory write port; read row byte reads six entry bytes
// then the row byte on the read port. clear, seal, verify: one memory byte per cycle.
// after reset a clearing pass runs over the page past the header; in_ready stays low.
// a two-entry command queue keeps accepting, until full, while the back end waits on out_ready.
module slotted_page_buffer_engine_core
    import spbe_pkg::*;
#(
    parameter int PAGE_BYTES  = 8192,
    parameter int HEADER_AREA = 256,
    parameter int SLOT_LIMIT  = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [7:0]  data_byte,
    input  logic [15:0] row_length,
    input  logic [8:0]  slot_index,
    input  logic [15:0] byte_index,
    input  logic [12:0] address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        ok,
    output logic [7:0]  read_byte,
    output logic [15:0] row_length_out,
    output logic [15:0] slot_count,
    output logic [31:0] checksum,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic         page_number_wr;
    logic [31:0]  page_number_reg;
    spbe_cmd_t    f_cmd;
    spbe_cmd_t    q_cmd;
    logic         q_ready;
    logic         q_valid;
    logic         pop;
    logic         init_done;
    spbe_result_t result;

    assign in_ready = q_ready && init_done;
    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_PAGE_NUMBER) ? page_number_reg : 32'd0;
    assign page_number_wr = psel && penable && pwrite && (paddr == REG_PAGE_NUMBER);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_number_reg <= 32'd0;
        end
        else if (page_number_wr)
        begin
            page_number_reg <= pwdata;
        end
    end

    spbe_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .action     (action),
        .data_byte  (data_byte),
        .row_length (row_length),
        .slot_index (slot_index),
        .byte_index (byte_index),
        .address    (address),
        .cmd        (f_cmd)
    );

    spbe_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && in_ready),
        .push_cmd  (f_cmd),
        .not_full  (q_ready),
        .pop       (pop),
        .not_empty (q_valid),
        .head_cmd  (q_cmd)
    );

    spbe_back #(
        .PAGE_BYTES  (PAGE_BYTES),
        .HEADER_AREA (HEADER_AREA),
        .SLOT_LIMIT  (SLOT_LIMIT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .page_number (page_number_reg),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .pop         (pop),
        .init_done   (init_done),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result      (result)
    );

    assign ok             = result.ok;
    assign read_byte      = result.read_byte;
    assign row_length_out = result.row_length_out;
    assign slot_count     = result.slot_count;
    assign checksum       = result.checksum;

    // no item taken during the clearing pass
    a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> init_done)
        else $error("item accepted before clearing pass finished");

    // queue pops only when it holds an entry
    a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("command popped from empty queue");

    // an empty queue always has room
    a_empty_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> q_ready)
        else $error("queue full and empty at once");

endmodule
